@@ src/ffsa_pkg.sv @@
// shared types, status codes and controller/datapath command set for the segment allocator
package ffsa_pkg;

  localparam int CMD_W  = 1;
  localparam int SIZE_W = 16;
  localparam int TAG_W  = 16;
  localparam int STAT_W = 3;
  localparam int SEG_W  = 16;

  // status codes of a result word
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT    = 3'd1;
  localparam logic [STAT_W-1:0] ST_INUSE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STAT_W-1:0] ST_ZERO     = 3'd5;

  // request command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  // register index of pool_size
  localparam logic REG_POOL = 1'b0;

  localparam logic [31:0] POOL_RESET = 32'd2000;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_TAG_RD, S_TAG_CHK, S_FIT_START, S_FIT_RD, S_FIT_CHK,
    S_ALLOC_WR, S_DN_RD, S_DN_WR, S_A_RD, S_A_CAP, S_POS_RD, S_POS_CHK,
    S_MERGE, S_UP_RD, S_UP_WR, S_ERR, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_TAG_RD, OP_TAG_CHK, OP_IDX_CLR, OP_FIT_RD, OP_FIT_CHK,
    OP_ALLOC_WR, OP_DN_RD, OP_DN_WR, OP_DN_END, OP_A_RD, OP_A_CAP, OP_POS_RD,
    OP_POS_CHK, OP_MERGE, OP_UP_RD, OP_UP_WR, OP_UP_END, OP_RES_ERR, OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [STAT_W-1:0] err;
  } dp_cmd_t;

  typedef struct packed {
    logic need_init;
    logic zero_size;
    logic is_free;
    logic tag_hit;
    logic tag_last;
    logic slot_ok;
    logic at_count;
    logic fit_hit;
    logic exact;
    logic pos_less;
    logic lo;
    logic hi;
    logic free_full;
    logic dn_end;
    logic up_end;
    logic out_full;
  } dp_stat_t;

endpackage

@@ src/ffsa_req_if.sv @@
// request channel: command, size and tag words
interface ffsa_req_if;
  import ffsa_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SIZE_W-1:0] request_size;
  logic [TAG_W-1:0]  tag_id;

  modport source (output valid, command, request_size, tag_id, input ready);
  modport sink (input valid, command, request_size, tag_id, output ready);
endinterface

@@ src/ffsa_rsp_if.sv @@
// result channel: status and segment words
interface ffsa_rsp_if;
  import ffsa_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SEG_W-1:0]  seg_start;
  logic [SEG_W-1:0]  seg_length;

  modport source (output valid, status, seg_start, seg_length, input ready);
  modport sink (input valid, status, seg_start, seg_length, output ready);
endinterface

@@ src/ffsa_ctrl.sv @@
// sequencer that steps the datapath through tag scan, fit scan, merge and table shifts
module ffsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  ffsa_pkg::dp_stat_t stat,
  output ffsa_pkg::dp_cmd_t  cmd
);
  import ffsa_pkg::*;

  state_t            state, state_next;
  logic [STAT_W-1:0] err, err_next;

  // state and error code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      err   <= ST_OK;
    end else begin
      state <= state_next;
      err   <= err_next;
    end
  end

  assign req_ready = (state == S_IDLE) && !stat.need_init;

  // next state
  always_comb begin
    state_next = state;
    err_next   = err;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.is_free && stat.zero_size) begin
          err_next   = ST_ZERO;
          state_next = S_ERR;
        end else begin
          state_next = S_TAG_RD;
        end
      end
      S_TAG_RD: state_next = S_TAG_CHK;
      S_TAG_CHK: begin
        if (stat.tag_hit) begin
          if (stat.is_free) begin
            state_next = S_A_RD;
          end else begin
            err_next   = ST_INUSE;
            state_next = S_ERR;
          end
        end else if (stat.tag_last) begin
          if (stat.is_free) begin
            err_next   = ST_NOTFOUND;
            state_next = S_ERR;
          end else if (stat.slot_ok) begin
            state_next = S_FIT_START;
          end else begin
            err_next   = ST_FULL;
            state_next = S_ERR;
          end
        end else begin
          state_next = S_TAG_RD;
        end
      end
      S_FIT_START: state_next = S_FIT_RD;
      S_FIT_RD: begin
        if (stat.at_count) begin
          err_next   = ST_NOFIT;
          state_next = S_ERR;
        end else begin
          state_next = S_FIT_CHK;
        end
      end
      S_FIT_CHK: state_next = stat.fit_hit ? S_ALLOC_WR : S_FIT_RD;
      S_ALLOC_WR: state_next = stat.exact ? S_DN_RD : S_DONE;
      S_DN_RD: state_next = stat.dn_end ? S_DONE : S_DN_WR;
      S_DN_WR: state_next = S_DN_RD;
      S_A_RD: state_next = S_A_CAP;
      S_A_CAP: state_next = S_POS_RD;
      S_POS_RD: state_next = stat.at_count ? S_MERGE : S_POS_CHK;
      S_POS_CHK: state_next = stat.pos_less ? S_POS_RD : S_MERGE;
      S_MERGE: begin
        if (stat.lo && stat.hi) begin
          state_next = S_DN_RD;
        end else if (stat.lo || stat.hi) begin
          state_next = S_DONE;
        end else if (stat.free_full) begin
          err_next   = ST_FULL;
          state_next = S_ERR;
        end else begin
          state_next = S_UP_RD;
        end
      end
      S_UP_RD: state_next = stat.up_end ? S_DONE : S_UP_WR;
      S_UP_WR: state_next = S_UP_RD;
      S_ERR: state_next = S_DONE;
      S_DONE: begin
        if (!stat.out_full) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath command
  always_comb begin
    cmd.op  = OP_NONE;
    cmd.err = err;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) cmd.op = OP_LOAD;
      end
      S_TAG_RD: cmd.op = OP_TAG_RD;
      S_TAG_CHK: cmd.op = OP_TAG_CHK;
      S_FIT_START: cmd.op = OP_IDX_CLR;
      S_FIT_RD: begin
        if (!stat.at_count) cmd.op = OP_FIT_RD;
      end
      S_FIT_CHK: cmd.op = OP_FIT_CHK;
      S_ALLOC_WR: cmd.op = OP_ALLOC_WR;
      S_DN_RD: cmd.op = stat.dn_end ? OP_DN_END : OP_DN_RD;
      S_DN_WR: cmd.op = OP_DN_WR;
      S_A_RD: cmd.op = OP_A_RD;
      S_A_CAP: cmd.op = OP_A_CAP;
      S_POS_RD: begin
        if (!stat.at_count) cmd.op = OP_POS_RD;
      end
      S_POS_CHK: cmd.op = OP_POS_CHK;
      S_MERGE: cmd.op = OP_MERGE;
      S_UP_RD: cmd.op = stat.up_end ? OP_UP_END : OP_UP_RD;
      S_UP_WR: cmd.op = OP_UP_WR;
      S_ERR: cmd.op = OP_RES_ERR;
      S_DONE: begin
        if (!stat.out_full) cmd.op = OP_PUSH;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

@@ src/ffsa_dpath.sv @@
// tables, scan index, segment registers, config register and result register
module ffsa_dpath #(
  parameter int MAX_ALLOCS = 32,
  parameter int ADDR_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ffsa_pkg::dp_cmd_t           cmd,
  output ffsa_pkg::dp_stat_t          stat,
  input  logic [ffsa_pkg::CMD_W-1:0]  command,
  input  logic [ffsa_pkg::SIZE_W-1:0] request_size,
  input  logic [ffsa_pkg::TAG_W-1:0]  tag_id,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  ffsa_rsp_if.source                  rsp
);
  import ffsa_pkg::*;

  localparam int DEPTH = MAX_ALLOCS + 1;
  localparam int LW    = ADDR_BITS;
  localparam int FW    = $clog2(DEPTH);
  localparam int IW    = $clog2(DEPTH + 1);
  localparam int AW    = $clog2(MAX_ALLOCS);
  localparam logic [31:0] POOL_RST_W = POOL_RESET;
  localparam logic [LW-1:0] POOL_RST = POOL_RST_W[LW-1:0];

  typedef struct packed {
    logic [LW-1:0] start;
    logic [LW-1:0] len;
  } free_ent_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [LW-1:0]    start;
    logic [LW-1:0]    len;
  } alloc_ent_t;

  function automatic logic [SEG_W-1:0] to_seg(input logic [LW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[SEG_W-1:0];
  endfunction

  // tables
  free_ent_t  free_mem [DEPTH];
  alloc_ent_t alloc_mem [MAX_ALLOCS];
  free_ent_t  frow;
  alloc_ent_t arow;
  logic [MAX_ALLOCS-1:0] valid;

  // control and working registers
  logic              need_init;
  logic [LW-1:0]     pool;
  logic [IW-1:0]     count;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     pos;
  logic [AW-1:0]     slot;
  logic              slot_found;
  logic [AW-1:0]     aidx;
  logic [CMD_W-1:0]  cmd_q;
  logic [SIZE_W-1:0] size_q;
  logic [TAG_W-1:0]  tag_q;
  logic [LW-1:0]     fs, fl;
  logic [LW-1:0]     prev_s, prev_l, next_s, next_l;
  logic              have_prev, have_next;
  logic [STAT_W-1:0] res_status;
  logic [LW-1:0]     res_start, res_len;

  // config write decode
  logic          cfg_we;
  logic [31:0]   cfg_w;
  logic [LW-1:0] pool_wr;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_POOL);
  assign cfg_w  = {16'b0, pwdata[15:0]};
  assign pool_wr = cfg_w[LW-1:0];
  assign prdata = (paddr[2] == REG_POOL) ? 32'(pool) : 32'b0;

  // index helpers and arithmetic
  logic [AW-1:0] idx_a;
  logic [FW-1:0] idx_f;
  logic [IW:0]   idx_p1;
  logic [IW-1:0] idx_m1;
  logic [31:0]   size32, sum32, diff32;
  logic [LW:0]   lo_sum, hi_sum;
  assign idx_a  = idx[AW-1:0];
  assign idx_f  = idx[FW-1:0];
  assign idx_p1 = {1'b0, idx} + 1'b1;
  assign idx_m1 = idx - 1'b1;
  assign size32 = {16'b0, size_q};
  assign sum32  = 32'(fs) + size32;
  assign diff32 = 32'(fl) - size32;
  assign lo_sum = {1'b0, prev_s} + {1'b0, prev_l};
  assign hi_sum = {1'b0, fs} + {1'b0, fl};

  // status toward the controller
  always_comb begin
    stat.need_init = need_init;
    stat.zero_size = (size_q == '0);
    stat.is_free   = (cmd_q == CMD_FREE);
    stat.tag_hit   = valid[idx_a] && (arow.tag == tag_q);
    stat.tag_last  = (idx == IW'(MAX_ALLOCS - 1));
    stat.slot_ok   = slot_found || !valid[idx_a];
    stat.at_count  = (idx == count);
    stat.fit_hit   = (32'(frow.len) >= size32);
    stat.exact     = (32'(fl) == size32);
    stat.pos_less  = (frow.start < fs);
    stat.lo        = have_prev && (lo_sum == {1'b0, fs});
    stat.hi        = have_next && (hi_sum == {1'b0, next_s});
    stat.free_full = (count >= IW'(DEPTH));
    stat.dn_end    = (idx_p1 >= {1'b0, count});
    stat.up_end    = (idx == pos);
    stat.out_full  = rsp.valid;
  end

  // free table write and read ports
  logic          fwe;
  logic [FW-1:0] fwa, fra;
  free_ent_t     fwd;
  always_comb begin
    fwe = 1'b0;
    fwa = '0;
    fwd = '{start: '0, len: '0};
    fra = idx_f;
    case (cmd.op)
      OP_DN_RD: fra = idx_p1[FW-1:0];
      OP_UP_RD: fra = idx_m1[FW-1:0];
      default: fra = idx_f;
    endcase
    if (cfg_we || need_init) begin
      fwe = 1'b1;
      fwa = '0;
      fwd = '{start: '0, len: cfg_we ? pool_wr : pool};
    end else begin
      case (cmd.op)
        OP_ALLOC_WR: begin
          fwe = !stat.exact;
          fwa = pos[FW-1:0];
          fwd = '{start: sum32[LW-1:0], len: diff32[LW-1:0]};
        end
        OP_DN_WR, OP_UP_WR: begin
          fwe = 1'b1;
          fwa = idx_f;
          fwd = frow;
        end
        OP_UP_END: begin
          fwe = 1'b1;
          fwa = pos[FW-1:0];
          fwd = '{start: fs, len: fl};
        end
        OP_MERGE: begin
          if (stat.lo) begin
            fwe = 1'b1;
            fwa = idx_m1[FW-1:0];
            fwd = '{start: prev_s, len: prev_l + fl + (stat.hi ? next_l : '0)};
          end else if (stat.hi) begin
            fwe = 1'b1;
            fwa = idx_f;
            fwd = '{start: fs, len: next_l + fl};
          end
        end
        default: fwe = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fwe) free_mem[fwa] <= fwd;
    frow <= free_mem[fra];
  end

  // allocation table ports
  logic          awe;
  logic [AW-1:0] ara;
  assign awe = (cmd.op == OP_ALLOC_WR);
  assign ara = (cmd.op == OP_A_RD) ? aidx : idx_a;
  always_ff @(posedge clk) begin
    if (awe) alloc_mem[slot] <= '{tag: tag_q, start: fs, len: size32[LW-1:0]};
    arow <= alloc_mem[ara];
  end

  // control state: init flag, pool, count, valid bits, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      need_init <= 1'b1;
      pool      <= POOL_RST;
      count     <= IW'(POOL_RST != '0);
      valid     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      if (cmd.op == OP_PUSH) rsp.valid <= 1'b1;
      need_init <= 1'b0;
      if (cfg_we) begin
        pool  <= pool_wr;
        count <= IW'(pool_wr != '0);
        valid <= '0;
      end else begin
        case (cmd.op)
          OP_ALLOC_WR: valid[slot] <= 1'b1;
          OP_DN_END: count <= count - 1'b1;
          OP_UP_END: count <= count + 1'b1;
          OP_MERGE: begin
            if (stat.lo || stat.hi || !stat.free_full) valid[aidx] <= 1'b0;
          end
          default: count <= count;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_q      <= command;
        size_q     <= request_size;
        tag_q      <= tag_id;
        idx        <= '0;
        slot_found <= 1'b0;
      end
      OP_TAG_CHK: begin
        if (stat.tag_hit) aidx <= idx_a;
        if (!slot_found && !valid[idx_a]) begin
          slot       <= idx_a;
          slot_found <= 1'b1;
        end
        idx <= idx + 1'b1;
      end
      OP_IDX_CLR: idx <= '0;
      OP_FIT_CHK: begin
        if (stat.fit_hit) begin
          fs  <= frow.start;
          fl  <= frow.len;
          pos <= idx;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      OP_ALLOC_WR: begin
        idx        <= pos;
        res_status <= ST_OK;
        res_start  <= fs;
        res_len    <= size32[LW-1:0];
      end
      OP_DN_WR: idx <= idx + 1'b1;
      OP_A_CAP: begin
        fs        <= arow.start;
        fl        <= arow.len;
        idx       <= '0;
        have_prev <= 1'b0;
        have_next <= 1'b0;
      end
      OP_POS_CHK: begin
        if (stat.pos_less) begin
          prev_s    <= frow.start;
          prev_l    <= frow.len;
          have_prev <= 1'b1;
          idx       <= idx + 1'b1;
        end else begin
          next_s    <= frow.start;
          next_l    <= frow.len;
          have_next <= 1'b1;
        end
      end
      OP_MERGE: begin
        pos        <= idx;
        res_status <= ST_OK;
        res_start  <= fs;
        res_len    <= fl;
        if (!stat.lo && !stat.hi) idx <= count;
      end
      OP_UP_WR: idx <= idx_m1;
      OP_RES_ERR: begin
        res_status <= cmd.err;
        res_start  <= '0;
        res_len    <= '0;
      end
      default: idx <= idx;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUSH) begin
      rsp.status     <= res_status;
      rsp.seg_start  <= to_seg(res_start);
      rsp.seg_length <= to_seg(res_len);
    end
  end

endmodule

@@ src/first_fit_segment_allocator.sv @@
// top level of the first-fit segment allocator with coalescing
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    command, request_size, tag_id
//   rsp      out  valid / ready    status, seg_start, seg_length
//   apb      in   psel / penable   paddr, pwdata, prdata (pool_size at 0x0)
//
// one request at a time; a word takes a scan of the tag table plus a scan of the
// free table and a shift of its entries where needed, all set by the single read
// port of each table
// a finished word waits in the output register while the next request is taken;
// a new word is held back while the previous one is still waiting there
// reset is followed by an init write of the pool as a single free segment
module first_fit_segment_allocator #(
  parameter int MAX_ALLOCS = 32,
  parameter int ADDR_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  ffsa_req_if.sink    req,
  ffsa_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffsa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  ffsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // tables and registers
  ffsa_dpath #(
    .MAX_ALLOCS (MAX_ALLOCS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .command      (req.command),
    .request_size (req.request_size),
    .tag_id       (req.tag_id),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .rsp          (rsp)
  );

endmodule
